// ----- rtl/dtraj_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the drive enable and cosine trajectory block.
// Used by the controller, the datapath and the top level; depends on nothing.
package dtraj_pkg;

   // Drive control words of the enable sequence.
   localparam logic [15:0] CW_OFF       = 16'h0000;
   localparam logic [15:0] CW_SHUTDOWN  = 16'h0006;
   localparam logic [15:0] CW_SWITCH_ON = 16'h0007;
   localparam logic [15:0] CW_ENABLE    = 16'h000F;

   // Cyclic synchronous position mode.
   localparam logic signed [7:0] MODE_CSP = 8'sd8;

   // Fixed-point constants for building the profile table.
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;

   // Register reset values.
   localparam logic [20:0] ENABLE_STEP_RESET  = 21'd1000;
   localparam logic [23:0] SINE_PERIOD_RESET  = 24'd6283;
   localparam logic [19:0] MOTION_RANGE_RESET = 20'd100000;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_ENABLE_STEP  = 2'd0,
      CSR_SINE_PERIOD  = 2'd1,
      CSR_MOTION_RANGE = 2'd2
   } csr_index_type;

   // Enable sequence of the drive.
   typedef enum logic [2:0] {
      SEQ_WAIT      = 3'd0,
      SEQ_SHUTDOWN  = 3'd1,
      SEQ_SWITCH_ON = 3'd2,
      SEQ_ENABLE    = 3'd3,
      SEQ_MOTION    = 3'd4
   } seq_state_type;

   // Processing steps for one transaction.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_MULTIPLY,
      ST_SUM,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic        load_in;
      logic        decide_load;
      logic [15:0] drive_ctrl;
      logic        step_clear;
      logic        step_incr;
      logic        base_capture;
      logic        index_clear;
      logic        div_start;
      logic        lookup;
      logic        multiply;
      logic        sum;
      logic        emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic status_zero;
      logic hold_done;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/drive_enable_cosine_trajectory.sv -----
`timescale 1ns / 1ps
// Top level of the drive enable sequencer with raised-cosine position profile.
// Depends on dtraj_pkg, dtraj_ctrl, dtraj_dp and, below it, dtraj_div.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------------
//   req     | in        | req_tvalid/tready    | drive_status, fb_position
//   rsp     | out       | rsp_tvalid/tready    | cmd_position, drive_ctrl, drive_mode
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A transaction outside the motion phase, or with a zero status word, goes from the
// decide step straight to the result register load.
// In the motion phase the phase divider runs one quotient bit per cycle until it
// reports done, followed by the profile ROM read, the multiply, the sum and the
// load of the result register.
// One transaction is processed at a time; the next one is accepted while the previous
// result still waits in the output register, and a stalled result holds the
// sequencer before it may load the next one. Reset is synchronous and active high,
// restores the register defaults and returns the enable sequence to its wait state.
module drive_enable_cosine_trajectory
   import dtraj_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [15:0] drive_status, [47:16] fb_position
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [31:0] cmd_position, [47:32] drive_ctrl,
                                    // [55:48] drive_mode
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,   // 0 hold_length, 1 motion_period,
                                    // 2 motion_range
   input  logic [23:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // Registers are plain flops, so a write is always taken.
   assign csr_ready = 1'b1;

   // The controller owns the enable sequence and the per-transaction steps.
   dtraj_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds the counters, the divider, the ROM and the result register.
   dtraj_dp #(
      .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .in_drive_status (req_tdata[15:0]),
      .in_fb_position  (req_tdata[47:16]),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

endmodule

// ----- rtl/dtraj_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider for the motion phase: (index * 2^16) / period.
// Also returns index mod period. Depends on nothing but its parameter.
module dtraj_div #(
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [23:0]                dividend,
   input  logic [23:0]                divisor,
   output logic                       done,
   output logic [TABLE_ADDR_BITS-1:0] quotient,
   output logic [23:0]                remainder
);

   // Quotient bits 39 down to 16 - TABLE_ADDR_BITS are produced, one per cycle.
   localparam int STEPS = 24 + TABLE_ADDR_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);
   localparam logic [CNT_W-1:0] MOD_STEP  = CNT_W'(23);

   logic [23:0]                rem_ff, rem_in;
   logic [23:0]                dvd_ff;
   logic [23:0]                dsr_ff;
   logic [23:0]                mod_ff;
   logic [TABLE_ADDR_BITS-1:0] quot_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [24:0]                trial;
   logic                       qbit;

   always_comb begin
      trial = {rem_ff, dvd_ff[23]};
      if (trial >= {1'b0, dsr_ff}) begin
         rem_in = 24'(trial - {1'b0, dsr_ff});
         qbit   = 1'b1;
      end else begin
         rem_in = trial[23:0];
         qbit   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         dvd_ff  <= {dvd_ff[22:0], 1'b0};
         quot_ff <= {quot_ff[TABLE_ADDR_BITS-2:0], qbit};
         // After the index bits are consumed the partial remainder is index mod period.
         if (cnt_ff == MOD_STEP) begin
            mod_ff <= rem_in;
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = mod_ff;

endmodule

// ----- rtl/dtraj_dp.sv -----
`timescale 1ns / 1ps
// Datapath: configuration registers, sequence counters, profile ROM, multiplier
// and the result register. Depends on dtraj_pkg and dtraj_div.
module dtraj_dp
   import dtraj_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       sts,
   input  logic [15:0]         in_drive_status,
   input  logic signed [31:0]  in_fb_position,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [23:0]         csr_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [55:0]         rsp_tdata
);

   localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;

   typedef logic [TABLE_SIZE-1:0][16:0] profile_type;

   // Entry i is sin^2(pi*i/N) in Q1.16, built with a Q30 Taylor series.
   function automatic profile_type build_profile();
      logic [63:0] k;
      logic [63:0] t;
      logic [63:0] x2;
      logic [63:0] u;
      logic [63:0] s;
      logic [63:0] Denom;
      profile_type tbl;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         k  = (i <= TABLE_SIZE - i) ? 64'(i) : 64'(TABLE_SIZE - i);
         t  = (PI_Q30 * k) >> TABLE_ADDR_BITS;
         x2 = (t * t) >> 30;
         u  = Q30_ONE;
         for (int n = 8; n >= 1; n--) begin
            Denom = 64'((2 * n) * (2 * n + 1));
            u     = Q30_ONE - (((x2 * u) >> 30) / Denom);
         end
         s = (t * u) >> 30;
         if (s > Q30_ONE) begin
            s = Q30_ONE;
         end
         tbl[i] = 17'((((s * s) >> 30) + 64'd8192) >> 14);
      end
      return tbl;
   endfunction

   localparam profile_type PROFILE = build_profile();

   logic [20:0]                enable_ff;
   logic [23:0]                period_ff;
   logic [19:0]                range_ff;
   logic [15:0]                status_ff;
   logic [31:0]                actual_ff;
   logic [20:0]                step_ff;
   logic [20:0]                step_plus;
   logic [23:0]                index_ff;
   logic [31:0]                base_ff;
   logic [23:0]                period_eff;
   logic                       div_done;
   logic [TABLE_ADDR_BITS-1:0] div_quot;
   logic [23:0]                div_rem;
   logic [24:0]                rem_plus;
   logic [16:0]                height_ff;
   logic [36:0]                prod_ff;
   logic [36:0]                prod_round;
   logic [31:0]                tgt_ff;
   logic [15:0]                cw_ff;
   logic                       out_valid_ff;
   logic [31:0]                out_tgt_ff;
   logic [15:0]                out_cw_ff;

   assign period_eff = (period_ff == '0) ? 24'd1 : period_ff;
   assign step_plus  = step_ff + 21'd1;
   assign rem_plus   = {1'b0, div_rem} + 25'd1;
   assign prod_round = prod_ff + 37'd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= ENABLE_STEP_RESET;
         period_ff <= SINE_PERIOD_RESET;
         range_ff  <= MOTION_RANGE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ENABLE_STEP:  enable_ff <= csr_data[20:0];
            CSR_SINE_PERIOD:  period_ff <= csr_data;
            CSR_MOTION_RANGE: range_ff  <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         status_ff <= in_drive_status;
         actual_ff <= in_fb_position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         index_ff <= '0;
         base_ff  <= '0;
      end else begin
         if (cmd.step_clear) begin
            step_ff <= '0;
         end else if (cmd.step_incr) begin
            step_ff <= step_plus;
         end
         if (cmd.base_capture) begin
            base_ff <= actual_ff;
         end
         if (cmd.index_clear) begin
            index_ff <= '0;
         end else if (cmd.lookup) begin
            index_ff <= (rem_plus == {1'b0, period_eff}) ? 24'd0 : rem_plus[23:0];
         end
      end
   end

   dtraj_div #(
      .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (index_ff),
      .divisor   (period_eff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Profile ROM with registered read, then one 20x17 multiply.
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         height_ff <= PROFILE[div_quot];
      end
      if (cmd.multiply) begin
         prod_ff <= 37'(range_ff) * 37'(height_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide_load) begin
         tgt_ff <= actual_ff;
         cw_ff  <= cmd.drive_ctrl;
      end else if (cmd.sum) begin
         tgt_ff <= base_ff + 32'(prod_round[36:16]);
         cw_ff  <= CW_ENABLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_tgt_ff <= tgt_ff;
         out_cw_ff  <= cw_ff;
      end
   end

   assign sts.status_zero = (status_ff == '0);
   assign sts.hold_done   = (step_plus >= enable_ff);
   assign sts.div_done    = div_done;
   assign sts.out_free    = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {MODE_CSP, out_cw_ff, out_tgt_ff};

endmodule

// ----- rtl/dtraj_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: the drive enable sequence and the step sequencer of one transaction.
// Depends on dtraj_pkg; drives the datapath through ctrl_cmd_type.
module dtraj_ctrl
   import dtraj_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type sts
);

   ctrl_state_type state_ff, state_in;
   seq_state_type  seq_ff, seq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seq_ff   <= SEQ_WAIT;
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
      end
   end

   // Next state of the step sequencer and of the enable sequence.
   always_comb begin
      state_in = state_ff;
      seq_in   = seq_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_EMIT;
            if (!sts.status_zero) begin
               unique case (seq_ff)
                  SEQ_WAIT:      seq_in = SEQ_SHUTDOWN;
                  SEQ_SHUTDOWN:  if (sts.hold_done) seq_in = SEQ_SWITCH_ON;
                  SEQ_SWITCH_ON: if (sts.hold_done) seq_in = SEQ_ENABLE;
                  SEQ_ENABLE:    if (sts.hold_done) seq_in = SEQ_MOTION;
                  SEQ_MOTION:    state_in = ST_DIVIDE;
                  default:       seq_in = SEQ_WAIT;
               endcase
            end
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP:   state_in = ST_MULTIPLY;
         ST_MULTIPLY: state_in = ST_SUM;
         ST_SUM:      state_in = ST_EMIT;
         ST_EMIT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      cmd.drive_ctrl = CW_OFF;
      unique case (state_ff)
         ST_IDLE: cmd.load_in = req_tvalid;
         ST_DECIDE: begin
            cmd.decide_load = 1'b1;
            if (!sts.status_zero) begin
               unique case (seq_ff)
                  SEQ_WAIT: begin
                     cmd.drive_ctrl = CW_SHUTDOWN;
                     cmd.step_clear = 1'b1;
                  end
                  SEQ_SHUTDOWN: begin
                     cmd.drive_ctrl = CW_SHUTDOWN;
                     cmd.step_clear = sts.hold_done;
                     cmd.step_incr  = !sts.hold_done;
                  end
                  SEQ_SWITCH_ON: begin
                     cmd.drive_ctrl = CW_SWITCH_ON;
                     cmd.step_clear = sts.hold_done;
                     cmd.step_incr  = !sts.hold_done;
                  end
                  SEQ_ENABLE: begin
                     cmd.drive_ctrl   = CW_ENABLE;
                     cmd.step_clear   = sts.hold_done;
                     cmd.step_incr    = !sts.hold_done;
                     cmd.base_capture = sts.hold_done;
                     cmd.index_clear  = sts.hold_done;
                  end
                  SEQ_MOTION: cmd.div_start = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_DIVIDE:   ;
         ST_LOOKUP:   cmd.lookup   = 1'b1;
         ST_MULTIPLY: cmd.multiply = 1'b1;
         ST_SUM:      cmd.sum      = 1'b1;
         ST_EMIT:     cmd.emit     = sts.out_free;
         default: ;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

// ----- rtl/dtraj_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for drive_enable_cosine_trajectory, attached with bind.
// Depends on dtraj_pkg for the control word and mode constants.
module dtraj_checker
   import dtraj_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // No result is offered straight out of reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // One transaction is processed at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction accepted while busy");

   // Mode is always cyclic position and the control word is one of the sequence words.
   a_rsp_words: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:48] == MODE_CSP &&
         (rsp_tdata[47:32] == CW_OFF || rsp_tdata[47:32] == CW_SHUTDOWN ||
          rsp_tdata[47:32] == CW_SWITCH_ON || rsp_tdata[47:32] == CW_ENABLE))
      else $error("bad control word or mode in result");

endmodule

bind drive_enable_cosine_trajectory dtraj_checker u_dtraj_checker (.*);
